// ===== rtl/core/vced_pkg.sv =====
// vced_pkg: shared constants, state encoding and lookup tables of the
// variable-coefficient error diffusion halftoner
// no dependencies
package vced_pkg;

	localparam int CFG_BITS       = 11;
	localparam int WIDTH_RESET    = 1024;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int ERROR_BITS_DEF = 11;
	localparam int LEVEL_BITS     = 8;
	localparam int RAND_BITS      = 7;
	localparam int STR_BITS       = 7;
	localparam int FOLD_BITS      = 7;
	localparam int WEIGHT_BITS    = 21;
	localparam int SUM_BITS       = WEIGHT_BITS + 1;
	localparam int THR_BITS       = 8;
	localparam int PROD_BITS      = RAND_BITS + STR_BITS;
	localparam int RECIP_100      = 5243;
	localparam int RECIP_SHIFT    = 19;
	localparam int THR_FLAT       = 127;
	localparam int THR_BASE       = 128;
	localparam int LEVEL_MAX      = 255;
	localparam int FOLD_LIMIT     = 127;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_DIV,
		ST_WB,
		ST_WB2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] ahead;
		logic [WEIGHT_BITS-1:0] diag;
		logic [WEIGHT_BITS-1:0] below;
	} weights_t;

	localparam weights_t WEIGHT_ROM [128] = '{
		'{13,0,5},'{1300249,0,499250},'{214114,287,99357},'{351854,0,199965},
		'{801100,0,490999},'{606569,37983,355446},'{593140,75967,330891},
		'{579711,113951,306337},
		'{283141,75967,140891},'{552853,189918,257228},'{704075,297466,303694},
		'{76188,33644,33025},
		'{527209,243114,229676},'{521101,250719,228178},'{514994,258325,226679},
		'{508886,265931,225181},
		'{502779,273537,223682},'{496671,281143,222184},'{490564,288749,220686},
		'{484456,296355,219187},
		'{478349,303961,217689},'{472242,311567,216190},'{46613,31917,21469},
		'{467003,317873,215123},
		'{467872,316573,215554},'{22321,15013,10285},'{469610,313973,216416},
		'{470479,312673,216847},
		'{52372,34597,24142},'{472217,310073,217709},'{473086,308773,218140},
		'{157985,102491,72857},
		'{47482,30617,21900},'{472921,298013,229065},'{471018,289853,239128},
		'{469115,281693,249191},
		'{467211,273533,259254},'{465308,265374,269317},'{463405,257214,279380},
		'{153834,83018,96481},
		'{45959,24089,29950},'{452279,286018,261701},'{444960,331142,223897},
		'{437641,376266,186092},
		'{43024,42131,14826},'{427011,421930,151058},'{211850,211235,76914},
		'{210195,211505,78299},
		'{208540,211775,79684},'{413769,424091,162139},'{410459,424631,164909},
		'{407148,425171,167679},
		'{403838,425711,170449},'{400528,426251,173219},'{397217,426792,175990},
		'{393907,427332,178760},
		'{195298,213936,90765},'{193643,214206,92150},'{383976,428953,187070},
		'{380665,429493,189841},
		'{377355,430033,192611},'{374044,430573,195381},'{370734,431113,198151},
		'{367424,431654,200921},
		'{36411,43219,20369},'{366696,445475,187828},'{369279,458755,171964},
		'{185931,236018,78050},
		'{374445,485317,140236},'{188514,249299,62186},'{379611,511879,108509},
		'{382194,525159,92645},
		'{38477,53843,7678},'{388829,533848,77321},'{392881,529256,77861},
		'{396933,524664,78401},
		'{400986,520072,78941},'{40503,51547,7948},'{399240,493681,107078},
		'{393441,471883,134674},
		'{38764,45008,16227},'{381845,428284,189869},'{376047,406484,217468},
		'{370249,384683,245066},
		'{364451,362883,272664},'{35865,34108,30026},'{356905,343874,299219},
		'{355157,346665,298176},
		'{353409,349456,297133},'{351661,352247,296090},'{349913,355038,295047},
		'{348165,357829,294004},
		'{346417,360620,292961},'{344669,363411,291918},'{342921,366202,290875},
		'{34117,36899,28983},
		'{342623,367794,289581},'{172037,183297,144665},'{345524,365395,289079},
		'{346975,364195,288828},
		'{348425,362996,288577},'{174938,180898,144163},'{35132,36059,28807},
		'{346970,363719,289309},
		'{342614,366841,290543},'{338258,369963,291777},'{333902,373085,293011},
		'{16477,18810,14712},
		'{330357,376874,292767},'{331169,377542,291288},'{331980,378209,289810},
		'{332791,378876,288331},
		'{33360,37954,28685},'{334876,378285,286838},'{168074,188513,143412},
		'{337421,375767,286810},
		'{338694,374509,286796},'{169983,186625,143391},'{341239,371991,286768},
		'{342512,370733,286754},
		'{171892,184737,143370},'{345057,368215,286726},'{346330,366957,286712},
		'{173801,182849,143349},
		'{348875,364439,286684},'{175074,181590,143335},'{175710,180961,143328},
		'{35269,36066,28664}
	};

	localparam logic [STR_BITS-1:0] STRENGTH_ROM [128] = '{
		0,0,1,2,3,3,4,5,6,6, 7,8,9,9,10,11,12,12,13,14,
		15,15,16,17,18,18,19,20,21,21, 22,23,24,24,25,26,27,27,28,29,
		30,31,32,33,34,34,35,36,37,38, 38,39,40,41,42,42,43,44,45,46,
		46,47,48,49,50,53,56,59,62,65, 68,71,75,78,81,84,87,90,93,96,
		100,100,100,100,100,100,91,83,75,66, 58,50,41,33,25,17,21,26,31,35,
		40,45,50,54,58,62,66,70,71,73, 75,77,79,80,81,83,84,86,87,88,
		90,91,93,94,95,97,98,100
	};

endpackage

// ===== rtl/core/variable_coefficient_error_diffusion_top.sv =====
// variable_coefficient_error_diffusion_top: serpentine error diffusion halftoner
// with level-dependent weights and threshold modulation
// depends on vced_pkg, vced_ram, vced_div
//
// channel   direction  signals
// pixel     in         pixel_valid/pixel_ready: pixel_level, random_value, frame_start
// result    out        result_valid/result_ready: halftone_bit, row_end
// config    in         image_width_we: image_width
//
// one pixel at a time; the diagonal write-back state is skipped at the first column
// the error split runs in the shared two-lane divider
// line buffers are two ping-pong RAMs; read of the current row, read-modify-write of the next
// reset clears control only; buffers need no clearing, the first row reads zero
// a result not yet taken holds the output stage, which holds off the next pixel
module variable_coefficient_error_diffusion_top #(
	parameter int MAX_WIDTH  = vced_pkg::MAX_WIDTH_DEF,
	parameter int ERROR_BITS = vced_pkg::ERROR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              image_width_we,
	input  logic [vced_pkg::CFG_BITS-1:0]     image_width,
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  logic [vced_pkg::LEVEL_BITS-1:0]   pixel_level,
	input  logic [vced_pkg::RAND_BITS-1:0]    random_value,
	input  logic                              frame_start,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              halftone_bit,
	output logic                              row_end
);

	localparam int EB   = ERROR_BITS;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WCW  = $clog2(MAX_WIDTH + 1);
	localparam int WW   = (WCW > vced_pkg::CFG_BITS) ? WCW : vced_pkg::CFG_BITS;
	localparam int PW   = EB + vced_pkg::WEIGHT_BITS;
	localparam int RP   = vced_pkg::PROD_BITS + 14;
	localparam logic signed [EB+1:0] SAT_HI = (EB+2)'((1 <<< (EB - 1)) - 1);
	localparam logic signed [EB+1:0] SAT_LO = (EB+2)'(-(1 <<< (EB - 1)));

	function automatic logic [EB-1:0] sat(input logic signed [EB+1:0] v);
		logic [EB-1:0] r;
		if (v > SAT_HI) begin
			r = {1'b0, {(EB-1){1'b1}}};
		end else if (v < SAT_LO) begin
			r = {1'b1, {(EB-1){1'b0}}};
		end else begin
			r = v[EB-1:0];
		end
		return r;
	endfunction

	vced_pkg::state_t state_q, state_d;

	logic [vced_pkg::CFG_BITS-1:0] width_q;
	logic [CW-1:0]   col_q;
	logic            odd_q, first_q, bank_q;
	logic [EB-1:0]   carry_q;
	logic            result_valid_q, halftone_q, row_end_q;

	logic [vced_pkg::LEVEL_BITS-1:0] lvl_s1;
	logic [vced_pkg::PROD_BITS-1:0]  tprod_s1;
	logic            tflat_s1;
	logic [CW-1:0]   c_s1, x_s1;
	logic            last_s1;
	logic signed [EB:0] err_s2;
	logic            bit_s2;
	logic [vced_pkg::FOLD_BITS-1:0] fold_s2;

	// width clamp and position
	logic [WW-1:0]   w_wide, w_eff, wm1, col_eff, c_w;
	logic            odd_eff;
	logic [CW-1:0]   x_c;
	logic [vced_pkg::FOLD_BITS-1:0] fold_in, fold_acc;
	logic [vced_pkg::STR_BITS-1:0]  str_in;
	logic            accept;

	assign accept = pixel_valid && pixel_ready;
	assign w_wide = WW'(width_q);
	always_comb begin
		if (w_wide == '0) begin
			w_eff = WW'(1);
		end else if (w_wide > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_wide;
		end
		wm1     = w_eff - 1'b1;
		col_eff = frame_start ? '0 : WW'(col_q);
		odd_eff = frame_start ? 1'b0 : odd_q;
		c_w     = (col_eff > wm1) ? wm1 : col_eff;
		x_c     = odd_eff ? CW'(wm1 - c_w) : CW'(c_w);
	end

	assign fold_in = (pixel_level > vced_pkg::LEVEL_BITS'(vced_pkg::FOLD_LIMIT))
		? vced_pkg::FOLD_BITS'(vced_pkg::LEVEL_MAX - 32'(pixel_level))
		: vced_pkg::FOLD_BITS'(pixel_level);
	assign str_in = vced_pkg::STRENGTH_ROM[fold_in];

	// accumulate and threshold
	logic [EB-1:0]   rd0, rd1, rd_cur, rd_next;
	logic signed [EB+1:0] acc_sum, acc_ext, thr_ext, err_w;
	logic [EB-1:0]   acc;
	logic [RP-1:0]   tq_w;
	logic [vced_pkg::THR_BITS-1:0] thr;

	assign rd_cur  = bank_q ? rd1 : rd0;
	assign rd_next = bank_q ? rd0 : rd1;
	assign acc_sum = $signed({{(EB+2-vced_pkg::LEVEL_BITS){1'b0}}, lvl_s1})
		+ $signed({{2{carry_q[EB-1]}}, carry_q})
		+ (first_q ? '0 : $signed({{2{rd_cur[EB-1]}}, rd_cur}));
	assign acc     = sat(acc_sum);
	assign acc_ext = $signed({{2{acc[EB-1]}}, acc});
	assign tq_w    = (RP'(tprod_s1) * RP'(vced_pkg::RECIP_100)) >> vced_pkg::RECIP_SHIFT;
	assign thr     = tflat_s1 ? vced_pkg::THR_BITS'(vced_pkg::THR_FLAT)
		: vced_pkg::THR_BITS'(vced_pkg::THR_BASE) + vced_pkg::THR_BITS'(tq_w);
	assign thr_ext = $signed({{(EB+2-vced_pkg::THR_BITS){1'b0}}, thr});
	assign err_w   = (acc_ext > thr_ext)
		? acc_ext - (EB+2)'(vced_pkg::LEVEL_MAX) : acc_ext;
	assign fold_acc = (lvl_s1 > vced_pkg::LEVEL_BITS'(vced_pkg::FOLD_LIMIT))
		? vced_pkg::FOLD_BITS'(vced_pkg::LEVEL_MAX - 32'(lvl_s1))
		: vced_pkg::FOLD_BITS'(lvl_s1);

	// weight products into the divider
	vced_pkg::weights_t wt;
	logic [EB-1:0]   mag;
	logic [PW-1:0]   prod_a, prod_d;
	logic [vced_pkg::SUM_BITS-1:0] wsum;
	logic            div_start, div_busy;
	logic [EB-1:0]   q_a, q_d;

	assign wt     = vced_pkg::WEIGHT_ROM[fold_s2];
	assign mag    = err_s2[EB] ? EB'(-err_s2) : EB'(err_s2);
	assign prod_a = PW'(mag) * PW'(wt.ahead);
	assign prod_d = PW'(mag) * PW'(wt.diag);
	assign wsum   = vced_pkg::SUM_BITS'(wt.ahead) + vced_pkg::SUM_BITS'(wt.diag)
		+ vced_pkg::SUM_BITS'(wt.below);

	vced_div #(
		.QBITS(EB),
		.NBITS(PW),
		.DBITS(vced_pkg::SUM_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend_a (prod_a),
		.dividend_b (prod_d),
		.divisor    (wsum),
		.busy       (div_busy),
		.quot_a     (q_a),
		.quot_b     (q_d)
	);

	// error split
	logic signed [EB+1:0] ahead_w, diag_w, below_w, err_ext, diag_sum;
	logic [CW-1:0]   behind;

	assign err_ext   = $signed({err_s2[EB], err_s2});
	assign ahead_w   = err_s2[EB] ? -$signed((EB+2)'(q_a)) : $signed((EB+2)'(q_a));
	assign diag_w    = err_s2[EB] ? -$signed((EB+2)'(q_d)) : $signed((EB+2)'(q_d));
	assign below_w   = err_ext - ahead_w - diag_w;
	assign diag_sum  = $signed({{2{rd_next[EB-1]}}, rd_next}) + diag_w;
	assign behind    = odd_q ? x_s1 + 1'b1 : x_s1 - 1'b1;

	// line buffers
	logic            we0, we1, wr_en;
	logic [CW-1:0]   waddr, raddr;
	logic [EB-1:0]   wdata;

	assign we0 = wr_en && bank_q;
	assign we1 = wr_en && !bank_q;

	vced_ram #(.WIDTH(EB), .DEPTH(MAX_WIDTH)) u_buf0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
	);
	vced_ram #(.WIDTH(EB), .DEPTH(MAX_WIDTH)) u_buf1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
	);

	logic out_free;
	assign out_free = !result_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			vced_pkg::ST_IDLE: if (pixel_valid) state_d = vced_pkg::ST_ACC;
			vced_pkg::ST_ACC:  state_d = vced_pkg::ST_MUL;
			vced_pkg::ST_MUL:  state_d = vced_pkg::ST_DIV;
			vced_pkg::ST_DIV:  if (!div_busy) state_d = vced_pkg::ST_WB;
			vced_pkg::ST_WB:   state_d = (c_s1 != '0) ? vced_pkg::ST_WB2 : vced_pkg::ST_OUT;
			vced_pkg::ST_WB2:  state_d = vced_pkg::ST_OUT;
			vced_pkg::ST_OUT:  if (out_free) state_d = vced_pkg::ST_IDLE;
			default:           state_d = vced_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pixel_ready = 1'b0;
		div_start   = 1'b0;
		wr_en       = 1'b0;
		waddr       = x_s1;
		wdata       = sat(below_w);
		raddr       = behind;
		case (state_q)
			vced_pkg::ST_IDLE: begin
				pixel_ready = 1'b1;
				raddr       = x_c;
			end
			vced_pkg::ST_MUL:  div_start = 1'b1;
			vced_pkg::ST_WB:   wr_en = 1'b1;
			vced_pkg::ST_WB2: begin
				wr_en = 1'b1;
				waddr = behind;
				wdata = sat(diag_sum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= vced_pkg::ST_IDLE;
			width_q        <= vced_pkg::CFG_BITS'(vced_pkg::WIDTH_RESET);
			col_q          <= '0;
			odd_q          <= 1'b0;
			first_q        <= 1'b1;
			bank_q         <= 1'b0;
			carry_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (image_width_we) begin
				width_q <= image_width;
			end
			if (accept && frame_start) begin
				col_q   <= '0;
				odd_q   <= 1'b0;
				first_q <= 1'b1;
				carry_q <= '0;
			end
			if (state_q == vced_pkg::ST_WB) begin
				carry_q <= last_s1 ? '0 : sat(ahead_w);
			end
			if (state_q == vced_pkg::ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
				if (last_s1) begin
					col_q   <= '0;
					odd_q   <= !odd_q;
					first_q <= 1'b0;
					bank_q  <= !bank_q;
				end else begin
					col_q <= c_s1 + 1'b1;
				end
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_s1   <= pixel_level;
			tprod_s1 <= vced_pkg::PROD_BITS'(random_value) * vced_pkg::PROD_BITS'(str_in);
			tflat_s1 <= (str_in == '0);
			c_s1     <= CW'(c_w);
			x_s1     <= x_c;
			last_s1  <= (c_w == wm1);
		end
		if (state_q == vced_pkg::ST_ACC) begin
			err_s2  <= err_w[EB:0];
			bit_s2  <= (acc_ext > thr_ext);
			fold_s2 <= fold_acc;
		end
		if (state_q == vced_pkg::ST_OUT && out_free) begin
			halftone_q <= bit_s2;
			row_end_q  <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign halftone_bit = halftone_q;
	assign row_end      = row_end_q;

`ifndef SYNTHESIS
	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> state_q == vced_pkg::ST_ACC)
		else $error("accepted pixel did not enter accumulate");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vced_pkg::ST_IDLE |-> !div_busy)
		else $error("divider busy while idle");
	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		!(we0 && we1))
		else $error("both line buffers written at once");
	a_wb2_diag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vced_pkg::ST_WB2 |-> c_s1 != '0 && $past(state_q) == vced_pkg::ST_WB)
		else $error("diagonal write at the first column");
`endif

endmodule

// ===== rtl/core/vced_ram.sv =====
// vced_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module vced_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/vced_div.sv =====
// vced_div: two-lane restoring divider, one quotient bit per cycle per lane,
// sharing one divisor; quotients known to fit in QBITS bits
// no dependencies
module vced_div #(
	parameter int QBITS = 11,
	parameter int NBITS = 32,
	parameter int DBITS = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NBITS-1:0] dividend_a,
	input  logic [NBITS-1:0] dividend_b,
	input  logic [DBITS-1:0] divisor,
	output logic             busy,
	output logic [QBITS-1:0] quot_a,
	output logic [QBITS-1:0] quot_b
);

	localparam int CNT_BITS = $clog2(QBITS + 1);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NBITS-1:0]    rem_a_q, rem_b_q, dsr_q;
	logic [QBITS-1:0]    quot_a_q, quot_b_q;
	logic                ge_a, ge_b;

	assign ge_a = rem_a_q >= dsr_q;
	assign ge_b = rem_b_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(QBITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_a_q  <= dividend_a;
			rem_b_q  <= dividend_b;
			dsr_q    <= NBITS'(divisor) << (QBITS - 1);
			quot_a_q <= '0;
			quot_b_q <= '0;
		end else if (busy_q) begin
			rem_a_q  <= ge_a ? rem_a_q - dsr_q : rem_a_q;
			rem_b_q  <= ge_b ? rem_b_q - dsr_q : rem_b_q;
			quot_a_q <= {quot_a_q[QBITS-2:0], ge_a};
			quot_b_q <= {quot_b_q[QBITS-2:0], ge_b};
			dsr_q    <= dsr_q >> 1;
		end
	end

	assign busy   = busy_q;
	assign quot_a = quot_a_q;
	assign quot_b = quot_b_q;

endmodule
